// File: sv/rgbcw_pkg.sv
// ============================================================================
// rgbcw_pkg: shared types and constants of the RGB color wheel controller
// Channel count, field widths, command and register codes, and the
// sequencer state type.
// ============================================================================
package rgbcw_pkg;

    // Number of RGB channels driven by the block (1 to 8).
    localparam int NUM_CHANNELS = 5;
    // Channels that own configuration registers.
    localparam int REG_CHANS    = 5;

    localparam int CH_W    = 3;   // width of the channel fields
    localparam int COLOR_W = 24;  // packed color: red high byte, blue low byte
    localparam int LEVEL_W = 8;
    localparam int CMD_W   = 2;
    localparam int CFG_A_W = 3;
    localparam int IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [COLOR_W-1:0] FALLBACK_COLOR = 24'h4080FF;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL     = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_SWITCH = 2'd0,
        CMD_SET    = 2'd1,
        CMD_FLOW   = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_A_W-1:0] {
        REG_ENABLE    = 3'd0,
        REG_START_DEF = 3'd1,
        REG_DEFAULT_0 = 3'd2,
        REG_DEFAULT_1 = 3'd3,
        REG_DEFAULT_2 = 3'd4,
        REG_DEFAULT_3 = 3'd5,
        REG_DEFAULT_4 = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

endpackage

// File: sv/rgbcw_wheel.sv
// ============================================================================
// rgbcw_wheel: one step around the hexagonal color wheel
// Moves a packed color one increment along red, magenta, blue, cyan,
// green, yellow and back to red; a color off the wheel becomes pure red.
// ============================================================================
module rgbcw_wheel (
    input  logic [rgbcw_pkg::COLOR_W-1:0] i_color,
    output logic [rgbcw_pkg::COLOR_W-1:0] o_color
);

    logic [rgbcw_pkg::LEVEL_W-1:0] w_r;
    logic [rgbcw_pkg::LEVEL_W-1:0] w_g;
    logic [rgbcw_pkg::LEVEL_W-1:0] w_b;
    logic                          w_r_full;
    logic                          w_g_full;
    logic                          w_b_full;
    logic                          w_r_zero;
    logic                          w_g_zero;
    logic                          w_b_zero;

    assign w_r = i_color[23:16];
    assign w_g = i_color[15:8];
    assign w_b = i_color[7:0];

    assign w_r_full = (w_r == rgbcw_pkg::FULL_LEVEL);
    assign w_g_full = (w_g == rgbcw_pkg::FULL_LEVEL);
    assign w_b_full = (w_b == rgbcw_pkg::FULL_LEVEL);
    assign w_r_zero = (w_r == '0);
    assign w_g_zero = (w_g == '0);
    assign w_b_zero = (w_b == '0);

    // The edges are tested in wheel order; the first match wins.
    always_comb begin
        if (w_r_full && w_g_zero && !w_b_full) begin
            o_color = {w_r, w_g, w_b + 8'd1};
        end else if (!w_r_zero && w_g_zero && w_b_full) begin
            o_color = {w_r - 8'd1, w_g, w_b};
        end else if (w_r_zero && !w_g_full && w_b_full) begin
            o_color = {w_r, w_g + 8'd1, w_b};
        end else if (w_r_zero && w_g_full && !w_b_zero) begin
            o_color = {w_r, w_g, w_b - 8'd1};
        end else if (!w_r_full && w_g_full && w_b_zero) begin
            o_color = {w_r + 8'd1, w_g, w_b};
        end else if (w_r_full && !w_g_zero && w_b_zero) begin
            o_color = {w_r, w_g - 8'd1, w_b};
        end else begin
            o_color = {rgbcw_pkg::FULL_LEVEL, 8'd0, 8'd0};
        end
    end

endmodule

// File: sv/rgb_channel_controller_color_wheel_core.sv
// ============================================================================
// rgb_channel_controller_color_wheel_core: RGB LED channel controller
// Keeps drive color, saved color, on and flow flags per channel, runs the
// switch, set color and flow commands, and steps enabled flowing channels around
// the color wheel on each flow tick.
// ============================================================================
//
//  Channel   | Dir | Handshake            | Payload
//  ----------+-----+----------------------+-------------------------------
//  s_axis    | in  | tvalid / tready      | tdata: command operands,
//            |     |                      | tuser: command code
//  m_axis    | out | tvalid / tready      | tdata: channel status,
//            |     |                      | tuser: publish, tlast: last
//  cfg       | in  | write enable only    | register index and value
//
// A switch, set color or flow command is accepted in S_IDLE and then worked
// in S_EXEC, where the single shared datapath reads the channel entry,
// updates it and loads the output register. A flow tick walks the channels
// one per cycle through the same datapath and the wheel step unit, as long
// as the output register is free. Reset is synchronous and active low and
// clears all channel state, configuration, sequencer and output valid, but
// not the captured color or the output data. The input is not ready while a
// command is at work; when the output register is still full the sequencer
// holds on the current channel until the waiting result transfer completes.
module rgb_channel_controller_color_wheel_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Command stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [2:0] channel, [3] flag, [11:4] red_in, [19:12] green_in,
    // [27:20] blue_in, [31:28] zero
    input  logic [31:0]                     i_s_axis_tdata,
    // [1:0] cmd
    input  logic [rgbcw_pkg::CMD_W-1:0]     i_s_axis_tuser,
    // Result stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [2:0] out_channel, [10:3] pwm_red, [18:11] pwm_green,
    // [26:19] pwm_blue, [27] is_on, [28] flow_on, [31:29] zero
    output logic [31:0]                     o_m_axis_tdata,
    // [0] publish
    output logic                            o_m_axis_tuser,
    output logic                            o_m_axis_tlast,
    // Configuration writes
    input  logic                            i_cfg_wr_en,
    input  logic [rgbcw_pkg::CFG_A_W-1:0]   i_cfg_addr,
    input  logic [rgbcw_pkg::COLOR_W-1:0]   i_cfg_wr_data
);

    localparam int N  = rgbcw_pkg::NUM_CHANNELS;
    localparam int CW = rgbcw_pkg::COLOR_W;

    // Configuration registers.
    logic [rgbcw_pkg::REG_CHANS-1:0] r_enable_mask;
    logic [rgbcw_pkg::REG_CHANS-1:0] r_start_def_mask;
    logic [CW-1:0]                   r_def_color [rgbcw_pkg::REG_CHANS];

    // Per channel views of the registers; channels without registers read zero.
    logic [N-1:0]                    w_enable;
    logic [N-1:0]                    w_start_def;
    logic [CW-1:0]                   w_def_color [N];

    // Channel state.
    logic [CW-1:0]                   r_drive [N];
    logic [CW-1:0]                   r_saved [N];
    logic [N-1:0]                    r_on;
    logic [N-1:0]                    r_flow;

    // Sequencer.
    rgbcw_pkg::t_state               r_state;
    rgbcw_pkg::t_state               n_state;
    rgbcw_pkg::t_cmd                 r_cmd;
    logic [rgbcw_pkg::IDX_W-1:0]     r_ch;
    logic                            r_flag;
    logic [CW-1:0]                   r_rgb;
    logic [N-1:0]                    r_pend;

    // Output register.
    logic                            r_ovalid;
    logic [31:0]                     r_odata;
    logic                            r_ouser;
    logic                            r_olast;

    // Datapath signals.
    rgbcw_pkg::t_cmd                 w_in_cmd;
    logic [rgbcw_pkg::CH_W-1:0]      w_in_ch;
    logic                            w_accept;
    logic                            w_out_free;
    logic [CW-1:0]                   w_cur_drive;
    logic [CW-1:0]                   w_cur_saved;
    logic                            w_cur_on;
    logic                            w_cur_flow;
    logic [CW-1:0]                   w_wheel;
    logic [CW-1:0]                   w_on_color;
    logic [CW-1:0]                   w_new_drive;
    logic [CW-1:0]                   w_new_saved;
    logic                            w_new_on;
    logic                            w_new_flow;
    logic                            w_pub;
    logic                            w_last;
    logic                            w_wr;
    logic                            w_advance;
    logic [N-1:0]                    w_ch_bit;

    genvar gc;
    generate
        for (gc = 0; gc < N; gc++) begin : g_chan_cfg
            if (gc < rgbcw_pkg::REG_CHANS) begin : g_reg
                assign w_enable[gc]    = r_enable_mask[gc];
                assign w_start_def[gc] = r_start_def_mask[gc];
                assign w_def_color[gc] = r_def_color[gc];
            end else begin : g_noreg
                assign w_enable[gc]    = 1'b0;
                assign w_start_def[gc] = 1'b0;
                assign w_def_color[gc] = '0;
            end
        end
    endgenerate

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_mask    <= '0;
            r_start_def_mask <= '0;
            for (int i = 0; i < rgbcw_pkg::REG_CHANS; i++) begin
                r_def_color[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                rgbcw_pkg::REG_ENABLE: begin
                    r_enable_mask <= i_cfg_wr_data[rgbcw_pkg::REG_CHANS-1:0];
                end
                rgbcw_pkg::REG_START_DEF: begin
                    r_start_def_mask <= i_cfg_wr_data[rgbcw_pkg::REG_CHANS-1:0];
                end
                rgbcw_pkg::REG_DEFAULT_0: r_def_color[0] <= i_cfg_wr_data;
                rgbcw_pkg::REG_DEFAULT_1: r_def_color[1] <= i_cfg_wr_data;
                rgbcw_pkg::REG_DEFAULT_2: r_def_color[2] <= i_cfg_wr_data;
                rgbcw_pkg::REG_DEFAULT_3: r_def_color[3] <= i_cfg_wr_data;
                rgbcw_pkg::REG_DEFAULT_4: r_def_color[4] <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign w_in_cmd   = rgbcw_pkg::t_cmd'(i_s_axis_tuser);
    assign w_in_ch    = i_s_axis_tdata[2:0];
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_ovalid || i_m_axis_tready;

    // One read port into the channel state, addressed by the sequencer.
    assign w_cur_drive = r_drive[r_ch];
    assign w_cur_saved = r_saved[r_ch];
    assign w_cur_on    = r_on[r_ch];
    assign w_cur_flow  = r_flow[r_ch];

    assign w_ch_bit = N'(1) << r_ch;
    // Last result of a tick: no other channel remains pending.
    assign w_last   = ((r_pend & ~w_ch_bit) == '0);

    rgbcw_wheel u_wheel (
        .i_color (w_cur_drive),
        .o_color (w_wheel)
    );

    // Switch on picks the default or the saved color; black falls back.
    always_comb begin
        w_on_color = w_start_def[r_ch] ? w_def_color[r_ch] : w_cur_saved;
        if (w_on_color == '0) begin
            w_on_color = rgbcw_pkg::FALLBACK_COLOR;
        end
    end

    // Sequencer: next state and datapath control.
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_new_drive     = w_cur_drive;
        w_new_saved     = w_cur_saved;
        w_new_on        = w_cur_on;
        w_new_flow      = w_cur_flow;
        w_pub           = 1'b0;
        w_wr            = 1'b0;
        w_advance       = 1'b0;
        case (r_state)
            rgbcw_pkg::S_IDLE: begin
                // Ready is high here, so a valid command is taken this cycle.
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    if (w_in_cmd == rgbcw_pkg::CMD_TICK) begin
                        if ((r_flow & w_enable) != '0) begin
                            n_state = rgbcw_pkg::S_SCAN;
                        end
                    end else if ({1'b0, w_in_ch} < (rgbcw_pkg::CH_W+1)'(N)) begin
                        n_state = rgbcw_pkg::S_EXEC;
                    end
                end
            end
            rgbcw_pkg::S_EXEC: begin
                case (r_cmd)
                    rgbcw_pkg::CMD_SWITCH: begin
                        w_pub = 1'b1;
                        w_wr  = 1'b1;
                        if (r_flag) begin
                            w_new_drive = w_on_color;
                            w_new_saved = w_on_color;
                            w_new_on    = 1'b1;
                        end else begin
                            w_new_flow  = 1'b0;
                            w_new_saved = w_cur_drive;
                            w_new_drive = '0;
                            w_new_on    = 1'b0;
                        end
                    end
                    rgbcw_pkg::CMD_SET: begin
                        // A black request is dropped without a result.
                        w_pub       = 1'b1;
                        w_wr        = (r_rgb != '0);
                        w_new_drive = r_rgb;
                        w_new_saved = r_rgb;
                        w_new_on    = 1'b1;
                    end
                    rgbcw_pkg::CMD_FLOW: begin
                        // Only a change of the flow flag is acted upon.
                        w_wr = (r_flag != w_cur_flow);
                        if (r_flag) begin
                            w_new_flow = 1'b1;
                            w_new_on   = 1'b1;
                        end else begin
                            w_new_flow  = 1'b0;
                            w_new_saved = w_cur_drive;
                        end
                    end
                    default: ;
                endcase
                if (!w_wr) begin
                    n_state = rgbcw_pkg::S_IDLE;
                end else if (w_out_free) begin
                    n_state = rgbcw_pkg::S_IDLE;
                end else begin
                    // Hold until the waiting result has gone out.
                    w_wr = 1'b0;
                end
            end
            rgbcw_pkg::S_SCAN: begin
                w_new_drive = w_wheel;
                if (r_pend[r_ch]) begin
                    w_wr      = w_out_free;
                    w_advance = w_out_free;
                end else begin
                    w_advance = 1'b1;
                end
                if (w_advance && (r_ch == rgbcw_pkg::IDX_W'(N - 1))) begin
                    n_state = rgbcw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rgbcw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rgbcw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Command capture and scan position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd  <= rgbcw_pkg::CMD_SWITCH;
            r_ch   <= '0;
            r_flag <= 1'b0;
            r_pend <= '0;
        end else if (w_accept) begin
            r_cmd  <= w_in_cmd;
            r_flag <= i_s_axis_tdata[3];
            r_pend <= r_flow & w_enable;
            if (w_in_cmd == rgbcw_pkg::CMD_TICK) begin
                r_ch <= '0;
            end else begin
                r_ch <= w_in_ch[rgbcw_pkg::IDX_W-1:0];
            end
        end else if (r_state == rgbcw_pkg::S_SCAN) begin
            if (w_wr) begin
                r_pend <= r_pend & ~w_ch_bit;
            end
            if (w_advance) begin
                r_ch <= r_ch + rgbcw_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rgb <= {i_s_axis_tdata[11:4], i_s_axis_tdata[19:12],
                      i_s_axis_tdata[27:20]};
        end
    end

    // Channel state update, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_drive[i] <= '0;
                r_saved[i] <= '0;
            end
            r_on   <= '0;
            r_flow <= '0;
        end else if (w_wr) begin
            r_drive[r_ch] <= w_new_drive;
            r_saved[r_ch] <= w_new_saved;
            r_on[r_ch]    <= w_new_on;
            r_flow[r_ch]  <= w_new_flow;
        end
    end

    // Output register; a new result loads in the cycle the old one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_wr) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_odata <= {3'b000, w_new_flow, w_new_on, w_new_drive[7:0],
                        w_new_drive[15:8], w_new_drive[23:16],
                        rgbcw_pkg::CH_W'(r_ch)};
            r_ouser <= w_pub;
            // A single command always ends its run; a tick ends at its
            // final pending channel.
            r_olast <= (r_state == rgbcw_pkg::S_SCAN) ? w_last : 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tlast  = r_olast;

endmodule
